@@ design/btc_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and the volume table of the one-bit audio encoder.
// No dependencies.
package btc_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int REQ_DW       = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int VOLT_W       = 16;
   localparam int TGT_W        = ((SAMPLE_WIDTH > VOLT_W) ? SAMPLE_WIDTH : VOLT_W) + 3;
   localparam int BYTE_W       = 8;
   localparam int RSP_DW       = 2 * BYTE_W;
   localparam int LEVEL_W      = 3;
   localparam int CSR_AW       = 3;
   localparam int CSR_DW       = 32;

   localparam logic [VOLT_W-1:0] FULL_SCALE  = VOLT_W'(32768);
   localparam logic [VOLT_W-1:0] VOLT_OFFSET = VOLT_W'(8192);
   localparam logic [LEVEL_W-1:0] VOL_RESET  = LEVEL_W'(2);
   localparam logic [LEVEL_W-1:0] VOL_MAX    = LEVEL_W'(4);
   localparam logic REG_VOLUME = 1'b0;

   typedef struct packed {
      logic [3:0]        step_shift;
      logic [1:0]        sample_shift;
      logic [BYTE_W-1:0] mask;
   } btc_vol_type;

   typedef struct packed {
      logic signed [TGT_W-1:0] target;
      logic                    last;
   } btc_item_type;

   function automatic btc_vol_type vol_lookup(input logic [LEVEL_W-1:0] level);
      btc_vol_type r;
      unique case (level)
         3'd0:    r = '{step_shift: 4'd9,  sample_shift: 2'd3, mask: 8'hCC};
         3'd1:    r = '{step_shift: 4'd9,  sample_shift: 2'd2, mask: 8'hCC};
         3'd2:    r = '{step_shift: 4'd9,  sample_shift: 2'd2, mask: 8'hFF};
         3'd3:    r = '{step_shift: 4'd9,  sample_shift: 2'd1, mask: 8'hFF};
         default: r = '{step_shift: 4'd10, sample_shift: 2'd1, mask: 8'hFF};
      endcase
      return r;
   endfunction

endpackage

@@ design/btc_front.sv @@
`timescale 1ns / 1ps
// Input stage: takes samples, forms the shifted and offset target, pushes to the queue.
// Depends on btc_pkg.
module btc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [btc_pkg::REQ_DW-1:0]    req_tdata,
   input  logic                          req_tlast,
   input  logic [1:0]                    sample_shift,
   output logic                          push,
   output btc_pkg::btc_item_type         push_item,
   input  logic                          full
);
   import btc_pkg::*;

   logic                    vld_ff, vld_in;
   btc_item_type            item_ff, item_in;
   logic signed [TGT_W-1:0] sext;
   logic                    take;

   assign push       = vld_ff && !full;
   assign push_item  = item_ff;
   assign req_tready = !vld_ff || !full;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      sext    = TGT_W'($signed(req_tdata[SAMPLE_WIDTH-1:0]));
      item_in = item_ff;
      vld_in  = vld_ff;
      if (push) begin
         vld_in = 1'b0;
      end
      if (take) begin
         vld_in         = 1'b1;
         item_in.target = (sext >>> sample_shift) + $signed({{(TGT_W-VOLT_W){1'b0}}, VOLT_OFFSET});
         item_in.last   = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      item_ff <= item_in;
   end

endmodule

@@ design/btc_fifo.sv @@
`timescale 1ns / 1ps
// Two-entry queue between the input stage and the encoder.
// Depends on btc_pkg.
module btc_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  btc_pkg::btc_item_type push_item,
   input  logic                  pop,
   output btc_pkg::btc_item_type head,
   output logic                  full,
   output logic                  empty
);
   import btc_pkg::*;

   btc_item_type mem_ff [2];
   logic         wptr_ff, wptr_in;
   logic         rptr_ff, rptr_in;
   logic [1:0]   count_ff, count_in;

   assign full  = count_ff == 2'd2;
   assign empty = count_ff == 2'd0;
   assign head  = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff ^ push;
      rptr_in  = rptr_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wptr_ff] <= push_item;
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop && !full) |=> !empty)
      else $error("queue lost an entry");

endmodule

@@ design/btc_back.sv @@
`timescale 1ns / 1ps
// Encoder: steps the RC voltage model one bit per cycle and drives the result register.
// Depends on btc_pkg.
module btc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  btc_pkg::btc_vol_type       vol,
   input  btc_pkg::btc_item_type      head,
   input  logic                       empty,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [btc_pkg::RSP_DW-1:0] rsp_tdata,
   output logic                       rsp_tlast
);
   import btc_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_type;

   state_type               state_ff, state_in;
   logic [VOLT_W-1:0]       volt_ff, volt_in;
   logic signed [TGT_W-1:0] tgt_ff, tgt_in;
   logic signed [TGT_W-1:0] tgt2_ff, tgt2_in;
   logic [2:0]              pos_ff, pos_in;
   logic                    sel_ff, sel_in;
   logic                    alt_ff, alt_in;
   logic                    altbit_ff, altbit_in;
   logic [BYTE_W-1:0]       bits_ff, bits_in;
   logic [BYTE_W-1:0]       first_ff, first_in;
   logic [BYTE_W-1:0]       second_ff, second_in;
   logic                    last_ff, last_in;
   logic                    rvld_ff, rvld_in;
   logic [RSP_DW-1:0]       rdata_ff, rdata_in;
   logic                    rlast_ff, rlast_in;

   logic [VOLT_W-1:0]       up, down;
   logic signed [TGT_W-1:0] dh, dl, adh, adl, sum, mid;
   logic                    bit_up, bracket, bit_val;
   logic [BYTE_W-1:0]       byte_full;
   logic                    out_load;

   assign pop        = (state_ff == ST_IDLE) && !empty;
   assign rsp_tvalid = rvld_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tlast  = rlast_ff;
   assign out_load   = (state_ff == ST_DONE) && (!rvld_ff || rsp_tready);

   always_comb begin
      up      = volt_ff + ((FULL_SCALE - volt_ff) >> vol.step_shift);
      down    = volt_ff - (volt_ff >> vol.step_shift);
      dh      = $signed({{(TGT_W-VOLT_W){1'b0}}, up}) - tgt_ff;
      dl      = $signed({{(TGT_W-VOLT_W){1'b0}}, down}) - tgt_ff;
      adh     = dh[TGT_W-1] ? -dh : dh;
      adl     = dl[TGT_W-1] ? -dl : dl;
      bit_up  = adh < adl;
      bracket = !pos_ff[0] && !dh[TGT_W-1] && (dh != '0) && dl[TGT_W-1];
      sum     = $signed({{(TGT_W-VOLT_W){1'b0}}, volt_ff}) + head.target;
      mid     = (sum >>> 1) + $signed(TGT_W'(sum[TGT_W-1] & sum[0]));

      state_in  = state_ff;
      volt_in   = volt_ff;
      tgt_in    = tgt_ff;
      tgt2_in   = tgt2_ff;
      pos_in    = pos_ff;
      sel_in    = sel_ff;
      alt_in    = alt_ff;
      altbit_in = altbit_ff;
      bits_in   = bits_ff;
      first_in  = first_ff;
      second_in = second_ff;
      last_in   = last_ff;
      rvld_in   = rvld_ff;
      rdata_in  = rdata_ff;
      rlast_in  = rlast_ff;
      bit_val   = 1'b0;
      byte_full = '0;

      if (rvld_ff && rsp_tready) begin
         rvld_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               tgt_in   = mid;
               tgt2_in  = head.target;
               last_in  = head.last;
               pos_in   = 3'd0;
               sel_in   = 1'b0;
               alt_in   = 1'b0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (alt_ff) begin
               bit_val   = ~altbit_ff;
               altbit_in = bit_val;
            end else if (bracket) begin
               bit_val   = bit_up;
               altbit_in = bit_val;
               alt_in    = 1'b1;
            end else begin
               bit_val = bit_up;
               volt_in = bit_up ? up : down;
            end
            byte_full = {bits_ff[BYTE_W-2:0], bit_val};
            bits_in   = byte_full;
            pos_in    = pos_ff + 3'd1;
            if (pos_ff == 3'd7) begin
               alt_in = 1'b0;
               if (!sel_ff) begin
                  first_in = byte_full & vol.mask;
                  tgt_in   = tgt2_ff;
                  sel_in   = 1'b1;
               end else begin
                  second_in = byte_full & vol.mask;
                  state_in  = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_load) begin
               rvld_in  = 1'b1;
               rdata_in = {second_ff, first_ff};
               rlast_in = last_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         volt_ff  <= VOLT_OFFSET;
         pos_ff   <= 3'd0;
         sel_ff   <= 1'b0;
         alt_ff   <= 1'b0;
         rvld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         volt_ff  <= volt_in;
         pos_ff   <= pos_in;
         sel_ff   <= sel_in;
         alt_ff   <= alt_in;
         rvld_ff  <= rvld_in;
      end
      tgt_ff    <= tgt_in;
      tgt2_ff   <= tgt2_in;
      altbit_ff <= altbit_in;
      bits_ff   <= bits_in;
      first_ff  <= first_in;
      second_ff <= second_in;
      last_ff   <= last_in;
      rdata_ff  <= rdata_in;
      rlast_ff  <= rlast_in;
   end

   assert property (@(posedge clock) disable iff (reset) volt_ff <= FULL_SCALE)
      else $error("voltage model out of range");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (pos_ff == 3'd0 && !alt_ff))
      else $error("bit counter not cleared between samples");
   assert property (@(posedge clock) disable iff (reset) out_load |=> rvld_ff)
      else $error("result not presented");
   assert property (@(posedge clock) disable iff (reset)
      alt_ff |=> $stable(volt_ff))
      else $error("voltage moved during alternating tail");

endmodule

@@ design/btc_one_bit_audio_encoder.sv @@
`timescale 1ns / 1ps
// Top level of the one-bit audio encoder: register port, input stage, queue, encoder.
// Depends on btc_pkg, btc_front, btc_fifo, btc_back.
//
//  channel | ports   | transaction
//  input   | req_*   | tdata[15:0] sample, tlast end_of_block
//  result  | rsp_*   | tdata[7:0] first_byte, [15:8] second_byte, tlast last_out
//  config  | csr_*   | volume_level at byte address 0
//
// For each item the encoder loads it and forms the midpoint, takes sixteen
// single-bit steps of the voltage model (the voltage update loop), then fills the
// result register. The input stage and two-entry queue absorb up to three
// further samples. Reset sets the voltage to 8192 and volume_level to 2.
// A stalled result holds the encoder in its final state until taken.
module btc_one_bit_audio_encoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [btc_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [btc_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [btc_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [btc_pkg::REQ_DW-1:0]    req_tdata,  // sample
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [btc_pkg::RSP_DW-1:0]    rsp_tdata,  // first_byte, second_byte
   output logic                          rsp_tlast
);
   import btc_pkg::*;

   logic [LEVEL_W-1:0] level_ff, level_in;
   btc_vol_type        vol;
   logic               push, pop, full, empty;
   btc_item_type       push_item, head;
   logic               wr;

   assign csr_pready = 1'b1;
   assign csr_prdata = CSR_DW'(level_ff);
   assign wr         = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign vol        = vol_lookup(level_ff);

   always_comb begin
      level_in = level_ff;
      if (wr && csr_paddr[2] == REG_VOLUME) begin
         level_in = (csr_pwdata[LEVEL_W-1:0] > VOL_MAX) ? VOL_MAX : csr_pwdata[LEVEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= VOL_RESET;
      end else begin
         level_ff <= level_in;
      end
   end

   btc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .sample_shift (vol.sample_shift),
      .push         (push),
      .push_item    (push_item),
      .full         (full)
   );

   btc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .full      (full),
      .empty     (empty)
   );

   btc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .vol        (vol),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ dv/btc_checker.sv @@
`timescale 1ns / 1ps
// Checker for the one-bit audio encoder: tracks volume writes and accepted samples,
// predicts each byte pair from its own voltage model and compares every result.
// Depends on btc_pkg.
module btc_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [btc_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [btc_pkg::CSR_DW-1:0] csr_pwdata,
   input  logic                       csr_pready,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [btc_pkg::REQ_DW-1:0] req_tdata,
   input  logic                       req_tlast,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [btc_pkg::RSP_DW-1:0] rsp_tdata,
   input  logic                       rsp_tlast,
   output int                         fail_count,
   output int                         pending
);
   import btc_pkg::*;

   typedef struct {
      logic [BYTE_W-1:0] first_byte;
      logic [BYTE_W-1:0] second_byte;
      logic              last_out;
   } byte_pair_type;

   byte_pair_type     pairs_due[$];
   logic [LEVEL_W-1:0] level;
   int                volt;
   int                fails;

   assign fail_count = fails;

   function automatic int step_shift_of(input logic [LEVEL_W-1:0] lv);
      return (lv == VOL_MAX) ? 10 : 9;
   endfunction

   function automatic int sample_shift_of(input logic [LEVEL_W-1:0] lv);
      case (lv)
         3'd0:    return 3;
         3'd1,
         3'd2:    return 2;
         default: return 1;
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] mask_of(input logic [LEVEL_W-1:0] lv);
      return (lv < 3'd2) ? 8'hCC : 8'hFF;
   endfunction

   // Walks the voltage model through one byte aimed at aim; updates volt.
   function automatic logic [BYTE_W-1:0] encode_toward(input int aim, input int sh);
      logic [BYTE_W-1:0] bits = '0;
      logic              b = 1'b0;
      bit                locked = 1'b0;
      int                up;
      int                down;
      int                dh;
      int                dl;
      for (int pos = 0; pos < BYTE_W; pos++) begin
         if (locked) begin
            b = ~b;
            bits = {bits[BYTE_W-2:0], b};
         end else begin
            up = volt + ((int'(FULL_SCALE) - volt) >>> sh);
            down = volt - (volt >>> sh);
            if ((pos % 2) == 0 && up > aim && down < aim) begin
               // target bracketed: alternate for the rest of the byte, hold voltage
               b = ((up - aim) < (aim - down));
               bits = {bits[BYTE_W-2:0], b};
               locked = 1'b1;
            end else begin
               dh = (up > aim) ? up - aim : aim - up;
               dl = (down > aim) ? down - aim : aim - down;
               if (dh < dl) begin
                  bits = {bits[BYTE_W-2:0], 1'b1};
                  volt = up;
               end else begin
                  bits = {bits[BYTE_W-2:0], 1'b0};
                  volt = down;
               end
            end
         end
      end
      return bits;
   endfunction

   always @(posedge clock) begin
      int            s;
      int            target;
      int            mid;
      byte_pair_type p;
      byte_pair_type want;
      logic [2:0]    wv;
      if (reset) begin
         level <= VOL_RESET;
         volt = int'(VOLT_OFFSET);
         pairs_due.delete();
         fails = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
               && csr_paddr[CSR_AW-1:2] == REG_VOLUME) begin
            wv = csr_pwdata[2:0];
            level <= (wv > VOL_MAX) ? VOL_MAX : wv;
         end
         if (req_tvalid && req_tready) begin
            s = int'($signed(req_tdata[SAMPLE_WIDTH-1:0]));
            target = (s >>> sample_shift_of(level)) + int'(VOLT_OFFSET);
            mid = (volt + target) / 2;
            p.first_byte = encode_toward(mid, step_shift_of(level)) & mask_of(level);
            p.second_byte = encode_toward(target, step_shift_of(level)) & mask_of(level);
            p.last_out = req_tlast;
            pairs_due.push_back(p);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pairs_due.size() == 0) begin
               $display("%0t unexpected result transaction: data %h last %b",
                        $time, rsp_tdata, rsp_tlast);
               fails++;
            end else begin
               want = pairs_due.pop_front();
               if (rsp_tdata[BYTE_W-1:0] !== want.first_byte) begin
                  $display("%0t first_byte expected %h actual %h",
                           $time, want.first_byte, rsp_tdata[BYTE_W-1:0]);
                  fails++;
               end
               if (rsp_tdata[2*BYTE_W-1:BYTE_W] !== want.second_byte) begin
                  $display("%0t second_byte expected %h actual %h",
                           $time, want.second_byte, rsp_tdata[2*BYTE_W-1:BYTE_W]);
                  fails++;
               end
               if (rsp_tlast !== want.last_out) begin
                  $display("%0t last_out expected %b actual %b",
                           $time, want.last_out, rsp_tlast);
                  fails++;
               end
            end
         end
      end
      pending <= pairs_due.size();
   end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Top of the one-bit audio encoder testbench: clock, reset, volume writes and sample
// stimulus with random idling; verdict from the checker. Depends on btc_pkg,
// btc_one_bit_audio_encoder and btc_checker.
module tb;
   import btc_pkg::*;

   localparam int LIMIT = 400000;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 178;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_DW-1:0] req_tdata = '0;   // sample
   logic              req_tlast = 1'b0; // end_of_block
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_DW-1:0] rsp_tdata;        // first_byte, second_byte
   logic              rsp_tlast;        // last_out

   int fail_count;
   int pending;
   int cycle_count = 0;
   int stall_pct = 0;
   int hold_left = 0;
   int gap_pct = 0;
   int wave = 0;

   btc_one_bit_audio_encoder DUT (.*);

   btc_checker u_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("btc_one_bit_audio_encoder regression: fail");
         $finish;
      end
   end

   // result-side backpressure in bursts
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         rsp_tready <= 1'b0;
         hold_left <= $urandom_range(0, 6);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic csr_write(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic send_sample(input int s, input logic last);
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DW'(s);
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic drain();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // mostly audio-like motion, with steady runs, jumps and extremes
   function automatic int next_sample();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) wave = wave + $urandom_range(0, 800) - 400;
      else if (pick < 60) wave = wave;
      else if (pick < 80) wave = int'($signed(16'($urandom)));
      else if (pick < 90) begin
         case ($urandom_range(0, 3))
            0: wave = -32768;
            1: wave = 32767;
            2: wave = 0;
            default: wave = -1;
         endcase
      end else wave = $urandom_range(0, 32) - 16;
      if (wave > 32767) wave = 32767;
      if (wave < -32768) wave = -32768;
      return wave;
   endfunction

   initial begin
      logic [CSR_AW-1:0] addr;
      logic [CSR_DW-1:0] value;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, at the reset volume
      send_sample(0, 1'b0);
      send_sample(0, 1'b1);
      send_sample(32767, 1'b0);
      send_sample(32767, 1'b0);
      send_sample(32767, 1'b1);
      send_sample(-32768, 1'b0);
      send_sample(-32768, 1'b0);
      send_sample(-32768, 1'b1);
      send_sample(-1, 1'b0);
      send_sample(1, 1'b0);
      send_sample(16'h5555, 1'b1);
      send_sample(-21846, 1'b0);
      send_sample(0, 1'b0);
      send_sample(0, 1'b0);
      send_sample(-32768, 1'b0);
      send_sample(32767, 1'b1);
      req_tvalid <= 1'b0;
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         repeat (4) @(posedge clock);
         addr = '0;
         case (ph)
            0: value = 0;
            1: value = 1;
            2: value = 3;
            3: value = 4;
            4: value = 5;
            5: value = 6;
            6: begin addr = 3'd4; value = 3'd1; end  // no register there
            7: value = 7;
            8: value = 0;
            default: value = 2;
         endcase
         value[CSR_DW-1:3] = $urandom;
         if (ph == 6) value = $urandom;
         csr_write(addr, value);
         if (ph == PHASES - 1) begin
            stall_pct = 0;
            gap_pct = 0;
         end else begin
            stall_pct = (ph % 3 == 1) ? 0 : $urandom_range(5, 40);
            gap_pct = (ph % 3 == 2) ? 0 : $urandom_range(5, 40);
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_sample(next_sample(), ($urandom_range(0, 7) == 0));
            if (ph == 2 && i == PHASE_ITEMS / 2) begin
               req_tvalid <= 1'b0;
               drain();
            end
         end
         req_tvalid <= 1'b0;
         drain();
      end

      repeat (60) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("btc_one_bit_audio_encoder regression: pass");
      end else begin
         $display("btc_one_bit_audio_encoder regression: fail");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/btc_pkg.sv
design/btc_front.sv
design/btc_fifo.sv
design/btc_back.sv
design/btc_one_bit_audio_encoder.sv
dv/btc_checker.sv
dv/tb.sv
